### hw/rtl/slt_pkg.sv
// Shared types and constants for the scheduler latency tracker.
`timescale 1ns / 1ps
package slt_pkg;

    localparam int TASK_W = 22;
    localparam int TIME_W = 64;
    localparam int CPU_W  = 12;
    localparam int HASH_W = 64;
    localparam int NAME_W = 128;

    localparam logic [HASH_W-1:0] FNV_BASIS     = 64'hcbf29ce484222325;
    // The prime is 2^40 + 0x1b3: a shift plus a narrow constant product.
    localparam int                FNV_PRIME_SH  = 40;
    localparam logic [8:0]        FNV_PRIME_LOW = 9'h1b3;

    typedef enum logic [1:0] {
        REQ_WAKEUP = 2'd0,
        REQ_SWITCH = 2'd1,
        REQ_EXIT   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] wake_time;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hash_stat_t;

endpackage

### hw/rtl/slt_fnv_unit.sv
// Byte-serial FNV-1a 64 hash unit over one zero-terminated name.
`timescale 1ns / 1ps
module slt_fnv_unit #(
    parameter int NAME_BYTES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [slt_pkg::NAME_W-1:0] name,
    output slt_pkg::hash_stat_t        stat,
    output logic [slt_pkg::HASH_W-1:0] hash
);
    import slt_pkg::*;

    localparam int CW = $clog2(NAME_BYTES + 1);

    logic              busy_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [NAME_W-1:0] name_reg;
    logic [CW-1:0]     cnt_reg;
    logic [7:0]        byte_val;
    logic              stop;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] hash_next;

    // Fold in one byte and multiply by the prime
    always_comb begin
        byte_val  = name_reg[7:0];
        stop      = (byte_val == 8'd0) || (cnt_reg == CW'(NAME_BYTES));
        mixed     = hash_reg ^ {{(HASH_W-8){1'b0}}, byte_val};
        hash_next = (mixed << FNV_PRIME_SH) + (mixed * {{(HASH_W-9){1'b0}}, FNV_PRIME_LOW});
    end

    // Step through the name one byte a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            hash_reg <= FNV_BASIS;
            name_reg <= name;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (stop) begin
                busy_reg <= 1'b0;
            end else begin
                hash_reg <= hash_next;
                name_reg <= name_reg >> 8;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && stop;
    assign hash      = hash_reg;

endmodule

### hw/rtl/sched_latency_tracker_top.sv
// Top level of the scheduler wakeup-to-run latency tracker.
`timescale 1ns / 1ps
// One item is taken at a time; s_ready is high only while the block is idle.
// The task store is a single-port-read memory kept packed: entries 0 to
// used-1 are live, a delete moves the last entry into the freed slot. Every
// lookup scans the live entries, each through a search state and a compare
// state. A switch first hashes both names one byte a cycle in one shared
// hash unit, then scans, then holds its record in the output register until
// m_ready takes it. The scan through the store's read port sets the cost as
// the store fills.
module sched_latency_tracker_top #(
    parameter int TABLE_SLOTS = 1024,
    parameter int NAME_BYTES  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [slt_pkg::TASK_W-1:0]  s_task_id,
    input  logic [slt_pkg::TIME_W-1:0]  s_event_time,
    input  logic [slt_pkg::CPU_W-1:0]   s_cpu_number,
    input  logic [63:0]                 s_prev_name_lo,
    input  logic [63:0]                 s_prev_name_hi,
    input  logic [63:0]                 s_next_name_lo,
    input  logic [63:0]                 s_next_name_hi,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [slt_pkg::HASH_W-1:0]  m_prev_name_hash,
    output logic [slt_pkg::HASH_W-1:0]  m_next_name_hash,
    output logic [slt_pkg::TIME_W-1:0]  m_wait_latency,
    output logic [slt_pkg::CPU_W-1:0]   m_cpu_out
);
    import slt_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_HP_GO   = 10'b0000000010,
        S_HP_WAIT = 10'b0000000100,
        S_HN_GO   = 10'b0000001000,
        S_HN_WAIT = 10'b0000010000,
        S_SEARCH  = 10'b0000100000,
        S_CMP     = 10'b0001000000,
        S_DEL_RD  = 10'b0010000000,
        S_DEL_WR  = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    req_type_t         kind_reg;
    logic [TASK_W-1:0] task_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [NAME_W-1:0] prev_name_reg;
    logic [NAME_W-1:0] next_name_reg;
    logic [HASH_W-1:0] prev_hash_reg;
    logic [HASH_W-1:0] next_hash_reg;
    logic [TIME_W-1:0] lat_reg;
    logic [CW-1:0]     used_reg;
    logic [CW-1:0]     idx_reg;

    entry_t            mem [TABLE_SLOTS];
    entry_t            rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;

    logic              hash_start;
    logic [NAME_W-1:0] hash_name;
    hash_stat_t        hash_stat;
    logic [HASH_W-1:0] hash_val;
    logic [CW-1:0]     last_idx;

    slt_fnv_unit #(
        .NAME_BYTES(NAME_BYTES)
    ) u_fnv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (hash_start),
        .name   (hash_name),
        .stat   (hash_stat),
        .hash   (hash_val)
    );

    assign last_idx   = used_reg - 1'b1;
    assign hash_start = (state_reg == S_HP_GO) || (state_reg == S_HN_GO);
    assign hash_name  = (state_reg == S_HN_GO) ? next_name_reg : prev_name_reg;

    // Store read and write ports
    always_comb begin
        rd_addr = (state_reg == S_DEL_RD) ? last_idx[AW-1:0] : idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = '{task_id: task_reg, wake_time: now_reg};
        if (state_reg == S_CMP && rd_data_reg.task_id == task_reg
                && kind_reg == REQ_WAKEUP) begin
            wr_en = 1'b1;
        end else if (state_reg == S_SEARCH && idx_reg == used_reg
                && kind_reg == REQ_WAKEUP && used_reg != CW'(TABLE_SLOTS)) begin
            wr_en = 1'b1;
        end else if (state_reg == S_DEL_WR) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_SWITCH) begin
                        state_next = S_HP_GO;
                    end else if (s_req_type == REQ_UNUSED) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_HP_GO:   state_next = S_HP_WAIT;
            S_HP_WAIT: if (hash_stat.done) state_next = S_HN_GO;
            S_HN_GO:   state_next = S_HN_WAIT;
            S_HN_WAIT: if (hash_stat.done) state_next = S_SEARCH;
            S_SEARCH: begin
                if (idx_reg == used_reg) begin
                    state_next = (kind_reg == REQ_SWITCH) ? S_OUT : S_IDLE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_data_reg.task_id == task_reg) begin
                    state_next = (kind_reg == REQ_WAKEUP) ? S_IDLE : S_DEL_RD;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_DEL_RD: state_next = S_DEL_WR;
            S_DEL_WR: state_next = (kind_reg == REQ_SWITCH) ? S_OUT : S_IDLE;
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_SEARCH && idx_reg == used_reg && kind_reg == REQ_WAKEUP
                    && used_reg != CW'(TABLE_SLOTS)) begin
                used_reg <= used_reg + 1'b1;
            end else if (state_reg == S_DEL_WR) begin
                used_reg <= last_idx;
            end
        end
    end

    // Latch the item, advance the scan, capture hashes and latency
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg      <= req_type_t'(s_req_type);
            task_reg      <= s_task_id;
            now_reg       <= s_event_time;
            cpu_reg       <= s_cpu_number;
            prev_name_reg <= {s_prev_name_hi, s_prev_name_lo};
            next_name_reg <= {s_next_name_hi, s_next_name_lo};
            idx_reg       <= '0;
            lat_reg       <= '0;
        end
        if (state_reg == S_HP_WAIT && hash_stat.done) begin
            prev_hash_reg <= hash_val;
        end
        if (state_reg == S_HN_WAIT && hash_stat.done) begin
            next_hash_reg <= hash_val;
        end
        if (state_reg == S_CMP) begin
            if (rd_data_reg.task_id == task_reg) begin
                if (now_reg >= rd_data_reg.wake_time) begin
                    lat_reg <= now_reg - rd_data_reg.wake_time;
                end
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_OUT);
    assign m_prev_name_hash = prev_hash_reg;
    assign m_next_name_hash = next_hash_reg;
    assign m_wait_latency   = lat_reg;
    assign m_cpu_out        = cpu_reg;

    // Fill count stays within the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(TABLE_SLOTS))
        else $error("fill count beyond store depth");

    // Fill count moves by at most one per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (used_reg == $past(used_reg)
            || used_reg == $past(used_reg) + 1'b1
            || used_reg == $past(used_reg) - 1'b1))
        else $error("fill count jumped");

    // Scan never passes the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH || state_reg == S_CMP) |-> idx_reg <= used_reg)
        else $error("scan index beyond live entries");

    // Never take an item while a record waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while record pending");

endmodule

### test/tb_sched_latency_tracker_top.sv
// Self-checking testbench for the scheduler wakeup-to-run latency tracker.
`timescale 1ns / 1ps
module tb_sched_latency_tracker_top;
    import slt_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;

    typedef struct {
        logic [63:0] prev_hash;
        logic [63:0] next_hash;
        logic [63:0] latency;
        logic [11:0] cpu;
    } switch_rec_t;

    // Tracks pending wakeups and the switch records they should produce.
    class latency_scoreboard;
        logic [63:0]  wake_at[logic [21:0]];
        switch_rec_t  pending_recs[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function int stored();
            return wake_at.num();
        endfunction

        function int pending();
            return pending_recs.size();
        endfunction

        task report(input string msg);
            $display("%0t MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // FNV-1a 64 over unsigned bytes, stopping at the first zero byte.
        function logic [63:0] fnv_name(input logic [127:0] name);
            logic [63:0] h;
            logic [7:0]  b;
            h = HASH_BASIS;
            for (int i = 0; i < 16; i++) begin
                b = name[8*i +: 8];
                if (b == 8'h00) break;
                h = (h ^ {56'h0, b}) * HASH_PRIME;
            end
            return h;
        endfunction

        function void note_event(input req_type_t kind, input logic [21:0] id,
                                 input logic [63:0] now, input logic [11:0] cpu,
                                 input logic [127:0] prev_name,
                                 input logic [127:0] next_name);
            switch_rec_t r;
            case (kind)
                REQ_WAKEUP: begin
                    // overwrite a known id; drop a new one when the store is full
                    if (wake_at.exists(id) || wake_at.num() < STORE_DEPTH)
                        wake_at[id] = now;
                end
                REQ_EXIT: begin
                    if (wake_at.exists(id)) wake_at.delete(id);
                end
                REQ_SWITCH: begin
                    r.latency = '0;
                    if (wake_at.exists(id)) begin
                        if (now >= wake_at[id]) r.latency = now - wake_at[id];
                        wake_at.delete(id);
                    end
                    r.prev_hash = fnv_name(prev_name);
                    r.next_hash = fnv_name(next_name);
                    r.cpu = cpu;
                    pending_recs.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task check_record(input logic [63:0] prev_hash, input logic [63:0] next_hash,
                          input logic [63:0] latency, input logic [11:0] cpu);
            switch_rec_t e;
            if (pending_recs.size() == 0) begin
                report("record with no switch outstanding");
            end else begin
                e = pending_recs.pop_front();
                if (prev_hash !== e.prev_hash)
                    report($sformatf("prev hash %h, want %h", prev_hash, e.prev_hash));
                if (next_hash !== e.next_hash)
                    report($sformatf("next hash %h, want %h", next_hash, e.next_hash));
                if (latency !== e.latency)
                    report($sformatf("latency %h, want %h", latency, e.latency));
                if (cpu !== e.cpu)
                    report($sformatf("cpu %h, want %h", cpu, e.cpu));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [21:0] s_task_id;
    logic [63:0] s_event_time;
    logic [11:0] s_cpu_number;
    logic [63:0] s_prev_name_lo, s_prev_name_hi, s_next_name_lo, s_next_name_hi;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_prev_name_hash, m_next_name_hash, m_wait_latency;
    logic [11:0] m_cpu_out;

    latency_scoreboard sb = new();
    logic [63:0] clock_ns;
    bit          send_burst, recv_burst;
    bit          stim_done;

    sched_latency_tracker_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_task_id(s_task_id),
        .s_event_time(s_event_time), .s_cpu_number(s_cpu_number),
        .s_prev_name_lo(s_prev_name_lo), .s_prev_name_hi(s_prev_name_hi),
        .s_next_name_lo(s_next_name_lo), .s_next_name_hi(s_next_name_hi),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prev_name_hash(m_prev_name_hash), .m_next_name_hash(m_next_name_hash),
        .m_wait_latency(m_wait_latency), .m_cpu_out(m_cpu_out)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // Present one item, hold it until accepted, then log it.
    task automatic send_item(input req_type_t kind, input logic [21:0] id,
                             input logic [63:0] now, input logic [11:0] cpu,
                             input logic [127:0] prev_name, input logic [127:0] next_name);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_task_id      <= id;
        s_event_time   <= now;
        s_cpu_number   <= cpu;
        s_prev_name_lo <= prev_name[63:0];
        s_prev_name_hi <= prev_name[127:64];
        s_next_name_lo <= next_name[63:0];
        s_next_name_hi <= next_name[127:64];
        do @(posedge aclk); while (!s_ready);
        sb.note_event(kind, id, now, cpu, prev_name, next_name);
    endtask

    // Drop valid and hold off until every outstanding record has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Random name: nonzero bytes up to a random terminator, junk after it.
    function automatic logic [127:0] rand_name();
        logic [127:0] n;
        int stop;
        n = {$urandom, $urandom, $urandom, $urandom};
        stop = $urandom_range(0, 20);
        for (int i = 0; i < 16; i++)
            if (n[8*i +: 8] == 8'h00) n[8*i +: 8] = 8'h5a;
        if (stop < 16) n[8*stop +: 8] = 8'h00;
        return n;
    endfunction

    // Mostly forward time, with occasional jumps backwards and to the extremes.
    function automatic logic [63:0] next_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) clock_ns = clock_ns + $urandom_range(0, 5000);
        else if (pick < 95) clock_ns = clock_ns - $urandom_range(1, 3000);
        else if (pick < 97) clock_ns = {$urandom, $urandom};
        else if (pick < 98) clock_ns = '0;
        else clock_ns = '1;
        return clock_ns;
    endfunction

    function automatic logic [21:0] pick_id();
        if ($urandom_range(0, 9) == 0) return 22'($urandom);
        return 22'($urandom_range(0, 23)) ^ 22'h2aaaa8;
    endfunction

    task automatic random_event();
        int pick;
        req_type_t kind;
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = REQ_WAKEUP;
        else if (pick < 75) kind = REQ_SWITCH;
        else if (pick < 95) kind = REQ_EXIT;
        else kind = REQ_UNUSED;
        send_item(kind, pick_id(), next_time(), 12'($urandom), rand_name(), rand_name());
    endtask

    // Result side: random stalls, log each record taken.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 9);
            repeat (gap) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_record(m_prev_name_hash, m_next_name_hash, m_wait_latency, m_cpu_out);
    end

    // Stimulus: directed cases, random mix, then fill the store past capacity.
    initial begin
        logic [21:0] id;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_WAKEUP;
        s_task_id      = '0;
        s_event_time   = '0;
        s_cpu_number   = '0;
        s_prev_name_lo = '0;
        s_prev_name_hi = '0;
        s_next_name_lo = '0;
        s_next_name_hi = '0;
        clock_ns       = 64'd1000;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        stim_done      = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hit, empty names, zero cpu
        send_item(REQ_WAKEUP, 22'd0, 64'd100, 12'h0, '0, '0);
        send_item(REQ_SWITCH, 22'd0, 64'd350, 12'h0, '0, '0);
        // clock backwards at the extremes of time and id
        send_item(REQ_WAKEUP, 22'h3fffff, '1, 12'hfff, '0, '0);
        send_item(REQ_SWITCH, 22'h3fffff, '0, 12'hfff, '1, '1);
        // full span of time
        send_item(REQ_WAKEUP, 22'h155555, '0, 12'h555, '0, '0);
        send_item(REQ_SWITCH, 22'h155555, '1, 12'haaa, {16{8'h80}}, {16{8'h7f}});
        // no entry on switch, exit for unknown id, unused kind
        send_item(REQ_SWITCH, 22'd5, 64'd9, 12'h123, {8'h41, {15{8'h00}}}, 128'h1);
        send_item(REQ_EXIT, 22'd6, 64'd10, 12'h0, '0, '0);
        send_item(REQ_UNUSED, 22'd6, 64'd11, 12'hfff, '1, '1);
        // overwrite, then exit, then switch finds nothing
        send_item(REQ_WAKEUP, 22'd7, 64'd20, 12'h1, '0, '0);
        send_item(REQ_WAKEUP, 22'd7, 64'd40, 12'h1, '0, '0);
        send_item(REQ_SWITCH, 22'd7, 64'd45, 12'h2, 128'h00ff_6162, 128'h6b73_6174);
        send_item(REQ_WAKEUP, 22'd8, 64'd50, 12'h1, '0, '0);
        send_item(REQ_EXIT, 22'd8, 64'd60, 12'h1, '0, '0);
        send_item(REQ_SWITCH, 22'd8, 64'd70, 12'h3, {8'hff, {15{8'h01}}}, '0);
        // equal times give zero latency
        send_item(REQ_WAKEUP, 22'h2aaaaa, 64'd77, 12'h0, '0, '0);
        send_item(REQ_SWITCH, 22'h2aaaaa, 64'd77, 12'h800, rand_name(), rand_name());
        drain();

        for (int i = 0; i < 300; i++) begin
            random_event();
            if (i == 150) drain();
        end

        // fill the store, then work against a full store
        while (sb.stored() < STORE_DEPTH) begin
            id = 22'($urandom);
            if (!sb.wake_at.exists(id))
                send_item(REQ_WAKEUP, id, next_time(), 12'($urandom), '0, '0);
        end
        for (int i = 0; i < 60; i++) begin
            if (i % 3 == 0) begin
                id = 22'($urandom) | 22'h1;
                send_item(REQ_WAKEUP, id, next_time(), 12'h0, '0, '0);
                send_item(REQ_SWITCH, id, next_time(), 12'($urandom), rand_name(),
                          rand_name());
            end else begin
                random_event();
            end
        end

        drain();
        repeat (3000) @(posedge aclk);
        while (sb.pending() > 0) begin
            sb.report("record never arrived");
            void'(sb.pending_recs.pop_front());
        end
        if (sb.errors == 0) begin
            $display("tb_sched_latency_tracker_top: done, clean");
        end else begin
            $display("tb_sched_latency_tracker_top: done, errors");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb_sched_latency_tracker_top: done, errors");
        $finish;
    end

endmodule

### sched_latency_tracker_top.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_fnv_unit.sv
hw/rtl/sched_latency_tracker_top.sv
test/tb_sched_latency_tracker_top.sv
